// ===== hdl/pte_aware_lru_replacement_assert.svh =====
// assertion macros for the pte aware lru replacement block
`ifndef PTE_AWARE_LRU_REPLACEMENT_ASSERT_SVH
`define PTE_AWARE_LRU_REPLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define PTE_LRU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pte lru check failed: same cycle");
// next-cycle implication, checked out of reset
`define PTE_LRU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pte lru check failed: next cycle");
`else
`define PTE_LRU_ASSERT_IMP(lbl, ante, cons)
`define PTE_LRU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/pte_lru_pkg.sv =====
// shared types and constants of the pte aware lru replacement block
`default_nettype none

package pte_lru_pkg;

    localparam int unsigned SET_IDX_W = 11;
    localparam int unsigned WAY_W     = 4;
    localparam int unsigned MASK_W    = 16;
    localparam int unsigned LIMIT_W   = 7;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned PCT_SCALE = 100;

    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_TOUCH  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LRU     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALT     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TOUCH   = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/pte_aware_lru_replacement.sv =====
// pte aware lru replacement: per-set rank and pte flag store with victim choice
//
//  channel   signals                                         direction  handshake
//  command   i_command i_set_index i_way i_is_pte            in         start && !busy
//            i_valid_mask
//  result    o_victim_way o_victim_kind                      out        o_done, one cycle
//  config    i_cfg_wdata (pte_ratio_limit)                   in         i_cfg_we
//
//  each item takes a read cycle for the set row, then a write-back cycle
//  that updates the row and counters; the next beat is taken during write-back
//  the row memory is used as single-port: one read, then one write per item
//  the result shows on o_done in the cycle after write-back, for one cycle only
//  after reset the row memory is swept to zero, one set a cycle, while busy is held
//  the receiver cannot stall; results are never held
`default_nettype none

`include "pte_aware_lru_replacement_assert.svh"

module pte_aware_lru_replacement
    import pte_lru_pkg::*;
#(
    parameter int SETS       = 2048,
    parameter int WAYS       = 16,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_command,
    input  wire logic [SET_IDX_W-1:0] i_set_index,
    input  wire logic [WAY_W-1:0]     i_way,
    input  wire logic                 i_is_pte,
    input  wire logic [MASK_W-1:0]    i_valid_mask,
    input  wire logic                 i_cfg_we,
    input  wire logic [LIMIT_W-1:0]   i_cfg_wdata,
    output logic                      o_done,
    output logic [WAY_W-1:0]          o_victim_way,
    output logic [KIND_W-1:0]         o_victim_kind
);

    // widths that follow from the parameters
    localparam int RB      = $clog2(WAYS);
    localparam int ROW_W   = WAYS * (RB + 1);
    localparam int SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int PROD_W  = COUNT_BITS + LIMIT_W;

    // set index modulo SETS by reciprocal multiply and one correction
    localparam int RECIP_K  = 22;
    localparam int RECIP_W  = RECIP_K + 1;
    localparam int QP_W     = SET_IDX_W + RECIP_W;
    localparam int QS_W     = SET_IDX_W + 17;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_K) / SETS);

    localparam logic [RB-1:0]         RANK_MAX = RB'(WAYS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

    // row memory: ranks in the low part, pte flags on top
    logic [ROW_W-1:0] mem [SETS];

    t_state r_state, n_state;

    logic                  r_cmd;
    logic [SET_IDX_W-1:0]  r_set_raw;
    logic [SET_IDX_W-1:0]  r_q;
    logic [WAY_W-1:0]      r_way;
    logic                  r_is_pte;
    logic [MASK_W-1:0]     r_mask;
    logic [SET_AW-1:0]     r_addr;
    logic [SET_AW-1:0]     r_clr_addr;
    logic [ROW_W-1:0]      r_rd_row;
    logic [LIMIT_W-1:0]    r_limit;
    logic [COUNT_BITS-1:0] r_evict_cnt;
    logic [COUNT_BITS-1:0] r_pte_cnt;
    logic [COUNT_BITS-1:0] r_evict_inc;
    logic [PROD_W-1:0]     r_lim_prod;
    logic [PROD_W-1:0]     r_pte_prod;

    logic accept;
    logic rd_en;
    logic wr_en;
    logic clr_active;
    logic calc;
    logic clr_last;

    logic [QP_W-1:0]       q_prod;
    logic [QS_W-1:0]       qs;
    logic [SET_IDX_W:0]    rem;
    logic [SET_IDX_W:0]    rem_fix;
    logic [SET_AW-1:0]     set_addr;

    logic [LIMIT_W-1:0]    lim;
    logic [COUNT_BITS-1:0] evict_inc;

    logic [RB-1:0]    cur_rank [WAYS];
    logic [WAYS-1:0]  cur_pte;
    logic [RB-1:0]    nxt_rank [WAYS];
    logic [WAYS-1:0]  nxt_pte;
    logic [ROW_W-1:0] new_row;
    logic [ROW_W-1:0] wr_row;
    logic [SET_AW-1:0] wr_addr;

    logic             all_valid;
    logic [RB-1:0]    inv_way;
    logic [RB-1:0]    lru_way;
    logic [WAYS-1:0]  present;
    logic             found_alt;
    logic [RB-1:0]    alt_rank;
    logic [RB-1:0]    alt_way;
    logic             take_alt;
    logic             way_ok;
    logic [RB-1:0]    way_idx;
    logic [RB-1:0]    old_rank;
    logic             cnt_evict;
    logic             cnt_pte;
    logic [WAY_W-1:0]  res_way;
    logic [KIND_W-1:0] res_kind;

    assign accept   = start && !busy;
    assign clr_last = (r_clr_addr == SET_AW'(SETS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                // back-to-back beats overlap the write-back with the next accept
                n_state = accept ? ST_READ : ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state decoded controls
    always_comb begin
        busy       = 1'b1;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        clr_active = 1'b0;
        calc       = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clr_active = 1'b1;
                wr_en      = 1'b1;
            end
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_READ: begin
                rd_en = 1'b1;
            end
            ST_WRITE: begin
                busy  = 1'b0;
                wr_en = 1'b1;
                calc  = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // quotient estimate straight off the input port, registered at accept
    assign q_prod = {{RECIP_W{1'b0}}, i_set_index} * {{SET_IDX_W{1'b0}}, RECIP};

    // remainder and at most one correction step in the read cycle
    always_comb begin
        qs      = {17'd0, r_q} * QS_W'(SETS);
        rem     = {1'b0, r_set_raw} - qs[SET_IDX_W:0];
        rem_fix = rem;
        if (32'(rem) >= 32'(SETS)) begin
            rem_fix = rem - (SET_IDX_W + 1)'(SETS);
        end
        set_addr = SET_AW'(rem_fix);
    end

    // ratio test operands, prepared in the read cycle
    assign lim       = {r_limit[LIMIT_W-1:1], 1'b1};
    assign evict_inc = (r_evict_cnt == CNT_MAX) ? CNT_MAX : r_evict_cnt + 1'b1;

    // unpack the row that was read
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            cur_rank[i] = r_rd_row[i*RB +: RB];
        end
        cur_pte = r_rd_row[WAYS*RB +: WAYS];
    end

    // victim search over the ways of the row
    always_comb begin
        all_valid = 1'b1;
        inv_way   = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!((i < MASK_W) ? r_mask[i] : 1'b0)) begin
                all_valid = 1'b0;
                inv_way   = RB'(i);
            end
        end

        // highest-numbered way at the oldest rank, way 0 if none
        lru_way = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (cur_rank[i] == RANK_MAX) begin
                lru_way = RB'(i);
            end
        end

        // which nonzero ranks are held by a data way
        present = '0;
        for (int i = 0; i < WAYS; i++) begin
            for (int v = 1; v < WAYS; v++) begin
                if (!cur_pte[i] && (cur_rank[i] == RB'(v))) begin
                    present[v] = 1'b1;
                end
            end
        end
        found_alt = |present;

        alt_rank = '0;
        for (int v = 1; v < WAYS; v++) begin
            if (present[v]) begin
                alt_rank = RB'(v);
            end
        end

        // lowest-numbered data way at that rank
        alt_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!cur_pte[i] && (cur_rank[i] == alt_rank)) begin
                alt_way = RB'(i);
            end
        end

        take_alt = found_alt && (r_pte_prod < r_lim_prod);
    end

    // row update for touch and for the alternate victim path
    always_comb begin
        way_ok   = (32'(r_way) < WAYS);
        way_idx  = RB'(r_way);
        old_rank = cur_rank[way_idx];
        nxt_rank = cur_rank;
        nxt_pte  = cur_pte;
        if (r_cmd == CMD_TOUCH) begin
            if (way_ok) begin
                for (int i = 0; i < WAYS; i++) begin
                    if ((cur_rank[i] <= old_rank) && (cur_rank[i] != RANK_MAX)) begin
                        nxt_rank[i] = cur_rank[i] + 1'b1;
                    end
                end
                nxt_rank[way_idx] = '0;
                nxt_pte[way_idx]  = r_is_pte;
            end
        end else if (all_valid && take_alt) begin
            // repair: ranks above the victim close the gap, victim goes oldest
            for (int i = 0; i < WAYS; i++) begin
                if (cur_rank[i] > alt_rank) begin
                    nxt_rank[i] = cur_rank[i] - 1'b1;
                end
            end
            nxt_rank[alt_way] = RANK_MAX;
        end

        for (int i = 0; i < WAYS; i++) begin
            new_row[i*RB +: RB] = nxt_rank[i];
        end
        new_row[WAYS*RB +: WAYS] = nxt_pte;
    end

    // result and counter events
    always_comb begin
        res_way   = '0;
        res_kind  = KIND_TOUCH;
        cnt_evict = 1'b0;
        cnt_pte   = 1'b0;
        if (r_cmd == CMD_VICTIM) begin
            if (!all_valid) begin
                res_way  = WAY_W'(inv_way);
                res_kind = KIND_INVALID;
            end else begin
                cnt_evict = 1'b1;
                if (take_alt) begin
                    res_way  = WAY_W'(alt_way);
                    res_kind = KIND_ALT;
                end else begin
                    res_way  = WAY_W'(lru_way);
                    res_kind = KIND_LRU;
                    cnt_pte  = cur_pte[lru_way];
                end
            end
        end
    end

    assign wr_row  = clr_active ? '0 : new_row;
    assign wr_addr = clr_active ? r_clr_addr : r_addr;

    // row memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            r_rd_row <= mem[set_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_limit     <= '0;
            r_evict_cnt <= '0;
            r_pte_cnt   <= '0;
            o_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= calc;
            if (clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (calc && cnt_evict) begin
                r_evict_cnt <= r_evict_inc;
            end
            if (calc && cnt_pte) begin
                r_pte_cnt <= (r_pte_cnt == CNT_MAX) ? CNT_MAX : r_pte_cnt + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_command;
            r_set_raw <= i_set_index;
            r_q       <= q_prod[RECIP_K +: SET_IDX_W];
            r_way     <= i_way;
            r_is_pte  <= i_is_pte;
            r_mask    <= i_valid_mask;
        end
        if (rd_en) begin
            r_addr      <= set_addr;
            r_evict_inc <= evict_inc;
            r_lim_prod  <= {{COUNT_BITS{1'b0}}, lim} * {{LIMIT_W{1'b0}}, evict_inc};
            r_pte_prod  <= {{LIMIT_W{1'b0}}, r_pte_cnt} * PROD_W'(PCT_SCALE);
        end
        if (calc) begin
            o_victim_way  <= res_way;
            o_victim_kind <= res_kind;
        end
    end

    `PTE_LRU_ASSERT_NXT(a_accept_reads, accept, r_state == ST_READ)
    `PTE_LRU_ASSERT_NXT(a_writeback_done, r_state == ST_WRITE, o_done)
    `PTE_LRU_ASSERT_NXT(a_done_spaced, o_done, !o_done)
    `PTE_LRU_ASSERT_IMP(a_touch_way_zero, o_done && (o_victim_kind == KIND_TOUCH), o_victim_way == '0)
    `PTE_LRU_ASSERT_IMP(a_pte_cnt_bound, 1'b1, r_pte_cnt <= r_evict_cnt)

endmodule

`default_nettype wire
